### src/rlh_pkg.sv
// Shared types, constants and the per-line run step for the run-length hint block.
package rlh_pkg;

   localparam int MAX_COLUMNS_DEFAULT = 64;
   localparam int MAX_ROWS_DEFAULT    = 64;

   localparam int CSR_W       = 7;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLUMNS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS    = 1'b1;

   localparam int LINE_W  = 6;
   localparam int POS_W   = 5;
   localparam int RUN_W   = 7;
   localparam int GIVEN_W = 6;

   localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
   localparam logic [GIVEN_W-1:0] GIVEN_MAX = '1;

   // Result queue depth, in items (each holds up to two results).
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic               along_row;
      logic [LINE_W-1:0]  line_number;
      logic [POS_W-1:0]   hint_position;
      logic [RUN_W-1:0]   run_length;
   } hint_type;

   typedef struct packed {
      logic     row_valid;
      hint_type row_hint;
      logic     col_valid;
      hint_type col_hint;
   } pair_type;

   typedef struct packed {
      logic [GIVEN_W-1:0] given;
      logic [RUN_W-1:0]   count;
   } line_state_type;

   localparam int LINE_STATE_W = GIVEN_W + RUN_W;

   typedef struct packed {
      logic first_row;
      logic line_end;
      logic pixel_on;
   } col_request_type;

   typedef struct packed {
      logic     valid;
      logic     emit;
      hint_type hint;
   } col_result_type;

   typedef struct packed {
      logic               emit;
      logic [RUN_W-1:0]   len;
      logic [GIVEN_W-1:0] pos;
      line_state_type     next;
   } step_type;

   // One pixel of one line: extend or close the open run, give a hint when due.
   function automatic step_type line_step(line_state_type cur, logic on, logic line_end);
      step_type         res;
      logic [RUN_W-1:0] cnt;
      logic             emit;
      cnt  = cur.count;
      emit = 1'b0;
      if (on) begin
         if (cnt != RUN_MAX) cnt = cnt + RUN_W'(1);
      end else if (cnt != '0) begin
         emit = 1'b1;
      end
      if (!emit && line_end && (cnt != '0 || cur.given == '0)) emit = 1'b1;
      res.emit       = emit;
      res.len        = cnt;
      res.pos        = cur.given;
      res.next.count = cnt;
      res.next.given = cur.given;
      if (emit) begin
         res.next.count = '0;
         if (cur.given != GIVEN_MAX) res.next.given = cur.given + GIVEN_W'(1);
      end
      if (line_end) begin
         res.next.count = '0;
         res.next.given = '0;
      end
      return res;
   endfunction

endpackage

### src/rlh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rlh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/rlh_col_unit.sv
// Per-column run state: RAM read, update and write-back with same-column forwarding.
module rlh_col_unit #(
   parameter int MAX_COLUMNS = rlh_pkg::MAX_COLUMNS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_en,
   input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] req_column,
   input  rlh_pkg::col_request_type    req_info,
   output rlh_pkg::col_result_type     result
);

   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   logic                       s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]           s1_column_ff;
   rlh_pkg::col_request_type   s1_info_ff;
   logic                       s1_bypass_ff;
   rlh_pkg::line_state_type    s1_bypass_data_ff;

   rlh_pkg::line_state_type    ram_q;
   logic [rlh_pkg::LINE_STATE_W-1:0] ram_rd_data;
   rlh_pkg::line_state_type    cur_state;
   rlh_pkg::step_type          step;

   rlh_ram #(
      .WIDTH (rlh_pkg::LINE_STATE_W),
      .DEPTH (MAX_COLUMNS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_column_ff),
      .wr_data (step.next),
      .rd_en   (req_en),
      .rd_addr (req_column),
      .rd_data (ram_rd_data)
   );

   assign ram_q = rlh_pkg::line_state_type'(ram_rd_data);

   // First row of an image starts from zero; never trust stale RAM contents there.
   always_comb begin
      priority if (s1_info_ff.first_row) cur_state = '0;
      else if (s1_bypass_ff)             cur_state = s1_bypass_data_ff;
      else                               cur_state = ram_q;
   end

   assign step = rlh_pkg::line_step(cur_state, s1_info_ff.pixel_on, s1_info_ff.line_end);

   assign s1_valid_in = req_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_en) begin
         s1_column_ff      <= req_column;
         s1_info_ff        <= req_info;
         // Forward the write that lands in the same cycle as this read.
         s1_bypass_ff      <= s1_valid_ff && (s1_column_ff == req_column);
         s1_bypass_data_ff <= step.next;
      end
   end

   always_comb begin
      result.valid              = s1_valid_ff;
      result.emit               = s1_valid_ff && step.emit;
      result.hint.along_row     = 1'b0;
      result.hint.line_number   = rlh_pkg::LINE_W'(s1_column_ff);
      result.hint.hint_position = rlh_pkg::POS_W'(step.pos);
      result.hint.run_length    = step.len;
   end

endmodule

### src/rlh_out_queue.sv
// Result queue: holds item result pairs and hands them out one result per beat.
module rlh_out_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rlh_pkg::pair_type push_entry,
   input  logic              reserve,
   output logic              no_room,
   output logic              out_valid,
   input  logic              out_stall,
   output rlh_pkg::hint_type out_hint,
   output logic              out_last
);

   localparam int DEPTH = rlh_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 2);

   rlh_pkg::pair_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              phase_ff, phase_in;
   rlh_pkg::pair_type head;
   logic              take, pop;

   assign head      = entry_ff[rd_ptr_ff];
   assign out_valid = (count_ff != '0);
   assign no_room   = (count_ff + CNT_W'(reserve)) >= CNT_W'(DEPTH);

   always_comb begin
      if (head.row_valid && !phase_ff) begin
         out_hint = head.row_hint;
         out_last = !head.col_valid;
      end else begin
         out_hint = head.col_hint;
         out_last = 1'b1;
      end
   end

   assign take = out_valid && !out_stall;
   assign pop  = take && out_last;

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + PTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + PTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
      phase_in  = pop ? 1'b0 : (take ? 1'b1 : phase_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

### src/binary_grid_run_length_hints.sv
// Top level of the run-length hint block: raster scan, row runs, column unit, result queue.
//
// Pixels enter on the req_ channel in raster order, one item per pixel, and the
// block reports every finished run of set pixels along rows and columns on the
// rsp_ channel. A line with no set pixel gives one hint of length zero at its
// last pixel. Each item causes zero, one or two results; when two, the row hint
// comes first, and last_of_item marks the final result of the item.
// A result passes through stage 1 and the result queue before it is offered. Rate: one
// pixel per cycle sustained while results drain; each result needs its own rsp_
// transfer, so items that cause two results limit the rate to the output side.
// Column state lives in a RAM with registered read; a pixel reads its column in
// the cycle it is accepted and writes it back the next cycle, with forwarding
// when the grid has a single column. Column state reads as zero on the first
// row of an image, so neither reset nor a size write needs a clearing pass.
// Grid size is written on the csr_ port; any write restarts the image. Reset
// sets both sizes to 64 and restarts the image. When rsp_stall holds, up to
// four items of results queue up; req_stall rises once queue and stage 1 hold four.
module binary_grid_run_length_hints #(
   parameter int MAX_COLUMNS = rlh_pkg::MAX_COLUMNS_DEFAULT,
   parameter int MAX_ROWS    = rlh_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_pixel_on,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_along_row,
   output logic [rlh_pkg::LINE_W-1:0]        rsp_line_number,
   output logic [rlh_pkg::POS_W-1:0]         rsp_hint_position,
   output logic [rlh_pkg::RUN_W-1:0]         rsp_run_length,
   output logic                              rsp_last_of_item,
   input  logic                              csr_write_en,
   input  logic [rlh_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rlh_pkg::CSR_W-1:0]         csr_data
);

   localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CSZ_W  = (COL_W + 1 > rlh_pkg::CSR_W) ? COL_W + 1 : rlh_pkg::CSR_W;
   localparam int RSZ_W  = (ROW_W + 1 > rlh_pkg::CSR_W) ? ROW_W + 1 : rlh_pkg::CSR_W;

   // Configuration registers
   logic [rlh_pkg::CSR_W-1:0] grid_columns_ff, grid_columns_in;
   logic [rlh_pkg::CSR_W-1:0] grid_rows_ff, grid_rows_in;
   logic                      restart;

   // Scan position and open row run
   logic [COL_W-1:0]        col_pos_ff, col_pos_in;
   logic [ROW_W-1:0]        row_pos_ff, row_pos_in;
   rlh_pkg::line_state_type row_state_ff, row_state_in;

   // Stage 1 row hint, aligned with the column unit's RAM read
   logic                    s1_row_emit_ff;
   rlh_pkg::hint_type       s1_row_hint_ff;

   logic [CSZ_W-1:0]        eff_cols;
   logic [RSZ_W-1:0]        eff_rows;
   logic                    row_end, col_end, accept;
   rlh_pkg::step_type       row_step;
   rlh_pkg::col_request_type col_req;
   rlh_pkg::col_result_type col_res;
   rlh_pkg::pair_type       pair;
   rlh_pkg::hint_type       out_hint;
   logic                    push, no_room;

   // Clamp sizes: zero acts as one, above the maximum acts as the maximum.
   always_comb begin
      priority if (grid_columns_ff == '0)
         eff_cols = CSZ_W'(1);
      else if (CSZ_W'(grid_columns_ff) > CSZ_W'(MAX_COLUMNS))
         eff_cols = CSZ_W'(MAX_COLUMNS);
      else
         eff_cols = CSZ_W'(grid_columns_ff);
      priority if (grid_rows_ff == '0)
         eff_rows = RSZ_W'(1);
      else if (RSZ_W'(grid_rows_ff) > RSZ_W'(MAX_ROWS))
         eff_rows = RSZ_W'(MAX_ROWS);
      else
         eff_rows = RSZ_W'(grid_rows_ff);
   end

   assign row_end = (CSZ_W'(col_pos_ff) + CSZ_W'(1)) >= eff_cols;
   assign col_end = (RSZ_W'(row_pos_ff) + RSZ_W'(1)) >= eff_rows;

   // Stall only on registered queue and stage 1 occupancy, never on req_valid.
   assign req_stall = no_room;
   assign accept    = req_valid && !req_stall;

   assign row_step = rlh_pkg::line_step(row_state_ff, req_pixel_on, row_end);

   // Configuration: any size write restarts the image.
   always_comb begin
      grid_columns_in = grid_columns_ff;
      grid_rows_in    = grid_rows_ff;
      restart         = 1'b0;
      if (csr_write_en) begin
         restart = 1'b1;
         unique case (csr_index)
            rlh_pkg::CSR_GRID_COLUMNS: grid_columns_in = csr_data;
            rlh_pkg::CSR_GRID_ROWS:    grid_rows_in    = csr_data;
            default:                   restart         = 1'b0;
         endcase
      end
   end

   // Advance the raster position and the open row run on each accepted item.
   always_comb begin
      col_pos_in   = col_pos_ff;
      row_pos_in   = row_pos_ff;
      row_state_in = row_state_ff;
      if (restart) begin
         col_pos_in   = '0;
         row_pos_in   = '0;
         row_state_in = '0;
      end else if (accept) begin
         row_state_in = row_step.next;
         if (row_end) begin
            col_pos_in = '0;
            row_pos_in = col_end ? '0 : ROW_W'(row_pos_ff + ROW_W'(1));
         end else begin
            col_pos_in = COL_W'(col_pos_ff + COL_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= rlh_pkg::CSR_W'(rlh_pkg::MAX_COLUMNS_DEFAULT);
         grid_rows_ff    <= rlh_pkg::CSR_W'(rlh_pkg::MAX_ROWS_DEFAULT);
         col_pos_ff      <= '0;
         row_pos_ff      <= '0;
         row_state_ff    <= '0;
      end else begin
         grid_columns_ff <= grid_columns_in;
         grid_rows_ff    <= grid_rows_in;
         col_pos_ff      <= col_pos_in;
         row_pos_ff      <= row_pos_in;
         row_state_ff    <= row_state_in;
      end
   end

   // Register the row hint so it meets the column hint of the same item in stage 1.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_emit_ff                <= row_step.emit;
         s1_row_hint_ff.along_row      <= 1'b1;
         s1_row_hint_ff.line_number    <= rlh_pkg::LINE_W'(row_pos_ff);
         s1_row_hint_ff.hint_position  <= rlh_pkg::POS_W'(row_step.pos);
         s1_row_hint_ff.run_length     <= row_step.len;
      end
   end

   always_comb begin
      col_req.first_row = (row_pos_ff == '0);
      col_req.line_end  = col_end;
      col_req.pixel_on  = req_pixel_on;
   end

   rlh_col_unit #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_col_unit (
      .clock      (clock),
      .reset      (reset),
      .req_en     (accept),
      .req_column (col_pos_ff),
      .req_info   (col_req),
      .result     (col_res)
   );

   // Drop items that give no hint; queue the rest as a row/column pair.
   always_comb begin
      pair.row_valid = s1_row_emit_ff;
      pair.row_hint  = s1_row_hint_ff;
      pair.col_valid = col_res.emit;
      pair.col_hint  = col_res.hint;
      push           = col_res.valid && (s1_row_emit_ff || col_res.emit);
   end

   rlh_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (pair),
      .reserve    (col_res.valid),
      .no_room    (no_room),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_hint   (out_hint),
      .out_last   (rsp_last_of_item)
   );

   assign rsp_along_row     = out_hint.along_row;
   assign rsp_line_number   = out_hint.line_number;
   assign rsp_hint_position = out_hint.hint_position;
   assign rsp_run_length    = out_hint.run_length;

`ifndef SYNTHESIS
   // A size write always restarts the scan at the top-left pixel.
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      csr_write_en && (csr_index == rlh_pkg::CSR_GRID_COLUMNS ||
                       csr_index == rlh_pkg::CSR_GRID_ROWS)
      |=> col_pos_ff == '0 && row_pos_ff == '0 && row_state_ff == '0)
      else $error("scan not restarted after size write");

   // The scan position stays inside the configured grid.
   a_pos_in_grid: assert property (@(posedge clock) disable iff (reset)
      CSZ_W'(col_pos_ff) < eff_cols && RSZ_W'(row_pos_ff) < eff_rows)
      else $error("scan position outside grid");

   // The first result of a two-result item is followed by the second.
   a_pair_completes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_item |=> rsp_valid && !rsp_along_row)
      else $error("second result of item missing");

   // An item leaving stage 1 always finds room in the result queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      accept |=> !(push && $past(no_room)))
      else $error("result queue overflow");
`endif

endmodule

### bench/tb_binary_grid_run_length_hints.sv
// Self-checking testbench for the nonogram run-length hint block.
`timescale 1ns / 1ps

module tb_binary_grid_run_length_hints;

   localparam int COLUMN_LIMIT   = rlh_pkg::MAX_COLUMNS_DEFAULT;
   localparam int ROW_LIMIT      = rlh_pkg::MAX_ROWS_DEFAULT;
   // Margin for the pipeline tail after the last owed hint has been seen.
   localparam int SETTLE_CYCLES  = 4;
   // Cycles without any handshake before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PIXELS  = 400;

   // How the pixels of one row are chosen.
   typedef enum int {
      ROW_EMPTY,
      ROW_FULL,
      ROW_ALTERNATE,
      ROW_RANDOM,
      ROW_MIXED
   } row_style_type;

   // One expected hint, as it should leave the rsp_ channel.
   typedef struct packed {
      rlh_pkg::hint_type hint;
      logic              last_of_item;
   } hint_expect_type;

   logic                            clock        = 1'b0;
   logic                            reset        = 1'b1;
   logic                            req_valid    = 1'b0;
   logic                            req_stall;
   logic                            req_pixel_on = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall    = 1'b0;
   logic                            rsp_along_row;
   logic [rlh_pkg::LINE_W-1:0]      rsp_line_number;
   logic [rlh_pkg::POS_W-1:0]       rsp_hint_position;
   logic [rlh_pkg::RUN_W-1:0]       rsp_run_length;
   logic                            rsp_last_of_item;
   logic                            csr_write_en = 1'b0;
   logic [rlh_pkg::CSR_INDEX_W-1:0] csr_index    = '0;
   logic [rlh_pkg::CSR_W-1:0]       csr_data     = '0;

   // Hints predicted but not yet seen, oldest first.
   hint_expect_type hints_due[$];

   int mismatch_count = 0;
   int pixels_sent    = 0;
   int quiet_cycles   = 0;
   int stall_left     = 0;

   // Idling switches for the pixel source and the hint sink.
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;

   // Shadow of the block: size registers and scan state.
   logic [rlh_pkg::CSR_W-1:0]   model_cols_reg;
   logic [rlh_pkg::CSR_W-1:0]   model_rows_reg;
   int unsigned                 scan_col;
   int unsigned                 scan_row;
   logic [rlh_pkg::RUN_W-1:0]   row_open_run;
   logic [rlh_pkg::GIVEN_W-1:0] row_hint_count;
   logic [rlh_pkg::RUN_W-1:0]   col_open_run   [COLUMN_LIMIT];
   logic [rlh_pkg::GIVEN_W-1:0] col_hint_count [COLUMN_LIMIT];

   binary_grid_run_length_hints u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_on      (req_pixel_on),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_along_row     (rsp_along_row),
      .rsp_line_number   (rsp_line_number),
      .rsp_hint_position (rsp_hint_position),
      .rsp_run_length    (rsp_run_length),
      .rsp_last_of_item  (rsp_last_of_item),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Hint predictor
   // ------------------------------------------------------------------

   // A size of zero acts as one; anything past the maximum acts as the maximum.
   function automatic int unsigned effective_size(logic [rlh_pkg::CSR_W-1:0] value,
                                                  int unsigned limit);
      if (value == '0) return 1;
      if (value > limit) return limit;
      return 32'(value);
   endfunction

   // Restart the image: positions, open runs and hint counters all go to zero.
   function automatic void clear_scan_model();
      scan_col       = 0;
      scan_row       = 0;
      row_open_run   = '0;
      row_hint_count = '0;
      for (int i = 0; i < COLUMN_LIMIT; i++) begin
         col_open_run[i]   = '0;
         col_hint_count[i] = '0;
      end
   endfunction

   // Feed one pixel to one line; flag a hint when a run closes or an empty line ends.
   function automatic void close_run(inout logic [rlh_pkg::RUN_W-1:0] open_run,
                                     inout logic [rlh_pkg::GIVEN_W-1:0] given,
                                     input bit on, input bit line_end,
                                     output bit due, output logic [rlh_pkg::RUN_W-1:0] len,
                                     output logic [rlh_pkg::GIVEN_W-1:0] pos);
      due = 1'b0;
      len = '0;
      pos = '0;
      if (on) begin
         // saturate rather than wrap
         if (open_run != rlh_pkg::RUN_MAX) open_run = open_run + rlh_pkg::RUN_W'(1);
      end else if (open_run != '0) begin
         due = 1'b1;
      end
      // a line with no set pixel still owes one zero-length hint at its end
      if (!due && line_end && (open_run != '0 || given == '0)) due = 1'b1;
      if (due) begin
         len = open_run;
         pos = given;
         if (given != rlh_pkg::GIVEN_MAX) given = given + rlh_pkg::GIVEN_W'(1);
         open_run = '0;
      end
      if (line_end) begin
         open_run = '0;
         given    = '0;
      end
   endfunction

   // Work out the hints one accepted pixel causes and queue them; row hint first.
   function automatic void predict_hints(bit on);
      int unsigned                 cols;
      int unsigned                 rows;
      int unsigned                 c;
      int unsigned                 r;
      bit                          row_end;
      bit                          col_end;
      bit                          due;
      logic [rlh_pkg::RUN_W-1:0]   len;
      logic [rlh_pkg::GIVEN_W-1:0] pos;
      hint_expect_type             one;
      hint_expect_type             found[$];
      cols = effective_size(model_cols_reg, COLUMN_LIMIT);
      rows = effective_size(model_rows_reg, ROW_LIMIT);
      c = (scan_col >= cols) ? cols - 1 : scan_col;
      r = (scan_row >= rows) ? rows - 1 : scan_row;
      row_end = (c + 1 >= cols);
      col_end = (r + 1 >= rows);

      close_run(row_open_run, row_hint_count, on, row_end, due, len, pos);
      if (due) begin
         one.hint.along_row     = 1'b1;
         one.hint.line_number   = rlh_pkg::LINE_W'(r);
         one.hint.hint_position = rlh_pkg::POS_W'(pos);
         one.hint.run_length    = len;
         one.last_of_item       = 1'b0;
         found.insert(found.size(), one);
      end
      close_run(col_open_run[c], col_hint_count[c], on, col_end, due, len, pos);
      if (due) begin
         one.hint.along_row     = 1'b0;
         one.hint.line_number   = rlh_pkg::LINE_W'(c);
         one.hint.hint_position = rlh_pkg::POS_W'(pos);
         one.hint.run_length    = len;
         one.last_of_item       = 1'b0;
         found.insert(found.size(), one);
      end
      if (found.size() > 0) found[found.size() - 1].last_of_item = 1'b1;
      foreach (found[i]) hints_due.insert(hints_due.size(), found[i]);

      // advance the raster position, wrapping to a new image after the last pixel
      if (row_end) begin
         scan_col = 0;
         scan_row = col_end ? 0 : r + 1;
      end else begin
         scan_col = c + 1;
         scan_row = r;
      end
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(string what);
      $display("[%0t ns] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [rlh_pkg::RUN_W-1:0] got,
                              logic [rlh_pkg::RUN_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   // Compare every accepted hint with the oldest one still owed.
   always @(posedge clock) begin : check_hints
      hint_expect_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (hints_due.size() == 0) begin
            report_mismatch($sformatf("unexpected hint: row %0d line %0d pos %0d len %0d",
                                      rsp_along_row, rsp_line_number, rsp_hint_position,
                                      rsp_run_length));
         end else begin
            want = hints_due.pop_front();
            check_field("along_row", rlh_pkg::RUN_W'(rsp_along_row),
                        rlh_pkg::RUN_W'(want.hint.along_row));
            check_field("line_number", rlh_pkg::RUN_W'(rsp_line_number),
                        rlh_pkg::RUN_W'(want.hint.line_number));
            check_field("hint_position", rlh_pkg::RUN_W'(rsp_hint_position),
                        rlh_pkg::RUN_W'(want.hint.hint_position));
            check_field("run_length", rsp_run_length, want.hint.run_length);
            check_field("last_of_item", rlh_pkg::RUN_W'(rsp_last_of_item),
                        rlh_pkg::RUN_W'(want.last_of_item));
         end
      end
   end

   // ------------------------------------------------------------------
   // Hint sink back-pressure: random stall bursts of random length.
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (!rx_idle_on) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run when neither channel moves for too long
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d hints still owed",
                  WATCHDOG_LIMIT, hints_due.size());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Offer one pixel, hold it until accepted, then predict its hints.
   task automatic send_pixel(bit on);
      int gap;
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_on <= on;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_hints(on);
      pixels_sent++;
   endtask

   // Drop valid, wait for every owed hint, then let the pipeline empty out.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (hints_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one size register while the block is idle; the write restarts the image.
   task automatic write_size(logic [rlh_pkg::CSR_INDEX_W-1:0] index,
                             logic [rlh_pkg::CSR_W-1:0] value);
      drain_and_settle();
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_data     <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (index == rlh_pkg::CSR_GRID_COLUMNS) model_cols_reg = value;
      else model_rows_reg = value;
      clear_scan_model();
   endtask

   // Send whole rows at the current width, each row filled as the style says.
   task automatic send_rows(int count, row_style_type style);
      int unsigned   cols;
      int            offset;
      int            density;
      row_style_type pick;
      bit            on;
      cols   = effective_size(model_cols_reg, COLUMN_LIMIT);
      offset = $urandom_range(0, 1);
      for (int y = 0; y < count; y++) begin
         pick    = (style == ROW_MIXED) ? row_style_type'($urandom_range(0, 3)) : style;
         density = $urandom_range(1, 99);
         for (int x = 0; x < cols; x++) begin
            case (pick)
               ROW_EMPTY:     on = 1'b0;
               ROW_FULL:      on = 1'b1;
               // checkerboard, so a single column alternates too
               ROW_ALTERNATE: on = ((x + y + offset) % 2) != 0;
               default:       on = ($urandom_range(0, 99) < density);
            endcase
            send_pixel(on);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset sizes of 64 by 64: only row runs that close mid-row report.
   task automatic test_default_grid();
      send_pixel(1'b1);
      send_pixel(1'b1);
      send_pixel(1'b1);
      send_pixel(1'b0);
      send_pixel(1'b1);
      send_pixel(1'b0);
   endtask

   // One-pixel grid: every pixel ends both its row and its column.
   task automatic test_single_pixel_grid();
      write_size(rlh_pkg::CSR_GRID_COLUMNS, 7'd1);
      write_size(rlh_pkg::CSR_GRID_ROWS, 7'd1);
      send_pixel(1'b1);
      send_pixel(1'b0);
      send_pixel(1'b1);
      send_pixel(1'b1);
   endtask

   // Zero acts as one, oversize values act as the maximum.
   task automatic test_clamped_sizes();
      write_size(rlh_pkg::CSR_GRID_COLUMNS, 7'd0);
      write_size(rlh_pkg::CSR_GRID_ROWS, 7'd0);
      send_pixel(1'b1);
      send_pixel(1'b0);
      write_size(rlh_pkg::CSR_GRID_COLUMNS, 7'd127);
      write_size(rlh_pkg::CSR_GRID_ROWS, 7'd2);
      send_pixel(1'b1);
      send_pixel(1'b1);
      send_pixel(1'b0);
      send_pixel(1'b1);
   endtask

   // A size write in the middle of an image drops the open runs and starts over.
   task automatic test_restart_mid_image();
      write_size(rlh_pkg::CSR_GRID_COLUMNS, 7'd3);
      write_size(rlh_pkg::CSR_GRID_ROWS, 7'd2);
      repeat (4) send_pixel(1'b1);
      write_size(rlh_pkg::CSR_GRID_COLUMNS, 7'd3);
      send_pixel(1'b0);
      send_pixel(1'b1);
      send_pixel(1'b1);
      send_pixel(1'b1);
      send_pixel(1'b0);
      send_pixel(1'b0);
   endtask

   // Random images over many grid sizes, with partial images left behind as noise.
   task automatic test_random_images();
      int          start;
      int          phase;
      int          images;
      int          noise;
      int unsigned cols_now;
      int unsigned rows_now;
      start = pixels_sent;
      phase = 0;
      while (pixels_sent - start < RANDOM_PIXELS) begin
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         if (phase == 0) begin
            // widest rows: a full run of 64 and 32 hints in one row
            write_size(rlh_pkg::CSR_GRID_COLUMNS, rlh_pkg::CSR_W'($urandom_range(64, 127)));
            write_size(rlh_pkg::CSR_GRID_ROWS, rlh_pkg::CSR_W'($urandom_range(0, 1)));
            send_rows(1, ROW_FULL);
            send_rows(1, ROW_ALTERNATE);
         end else if (phase == 1) begin
            // tallest column, alternating down its length
            write_size(rlh_pkg::CSR_GRID_ROWS, rlh_pkg::CSR_W'($urandom_range(64, 127)));
            write_size(rlh_pkg::CSR_GRID_COLUMNS, rlh_pkg::CSR_W'($urandom_range(0, 1)));
            send_rows(ROW_LIMIT, ROW_ALTERNATE);
         end else begin
            write_size(rlh_pkg::CSR_GRID_COLUMNS, rlh_pkg::CSR_W'($urandom_range(0, 9)));
            write_size(rlh_pkg::CSR_GRID_ROWS, rlh_pkg::CSR_W'($urandom_range(0, 9)));
            cols_now = effective_size(model_cols_reg, COLUMN_LIMIT);
            rows_now = effective_size(model_rows_reg, ROW_LIMIT);
            images   = $urandom_range(1, 3);
            for (int i = 0; i < images; i++) begin
               send_rows(rows_now, ROW_MIXED);
               // hold off the source until every owed hint is out
               if (phase == 2 || $urandom_range(0, 5) == 0) drain_and_settle();
            end
            // leave a broken image for the next size write to cut off
            if ($urandom_range(0, 3) == 0) begin
               noise = $urandom_range(1, cols_now * rows_now);
               repeat (noise) send_pixel(1'($urandom_range(0, 1)));
            end
         end
         phase++;
      end
   endtask

   // Back-to-back pixels and a sink that never stalls.
   task automatic test_steady_stream();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      write_size(rlh_pkg::CSR_GRID_COLUMNS, rlh_pkg::CSR_W'($urandom_range(2, 9)));
      write_size(rlh_pkg::CSR_GRID_ROWS, rlh_pkg::CSR_W'($urandom_range(2, 9)));
      send_rows(2 * effective_size(model_rows_reg, ROW_LIMIT), ROW_MIXED);
   endtask

   initial begin
      model_cols_reg = rlh_pkg::CSR_W'(COLUMN_LIMIT);
      model_rows_reg = rlh_pkg::CSR_W'(ROW_LIMIT);
      clear_scan_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_grid();
      test_single_pixel_grid();
      test_clamped_sizes();
      test_restart_mid_image();
      test_random_images();
      test_steady_stream();

      // everything sent: wait out the owed hints and the pipeline tail
      drain_and_settle();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
